// ===== design/nnsa_pkg.sv =====
// ----------------------------------------------------------------------------
// nnsa_pkg: shared types and constants of the scaler address generator
// Field widths, configuration register set, queue entry and size helper.
// ----------------------------------------------------------------------------
package nnsa_pkg;

  localparam int ACC_W      = 32;
  localparam int ADDR_W     = 24;
  localparam int STEP_W     = 24;
  localparam int SIZE_W     = 13;
  localparam int POS_W      = 12;
  localparam int STRIDE_W   = 14;
  localparam int START_W    = 12;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [ADDR_W-1:0] ADDR_MAX   = '1;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(4096);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_X      = 3'd0,
    CFG_STEP_Y      = 3'd1,
    CFG_OUT_WIDTH   = 3'd2,
    CFG_OUT_HEIGHT  = 3'd3,
    CFG_SRC_STRIDE  = 3'd4,
    CFG_DST_STRIDE  = 3'd5,
    CFG_DST_START_X = 3'd6,
    CFG_DST_START_Y = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step_x;
    logic [STEP_W-1:0]   step_y;
    logic [SIZE_W-1:0]   out_width;
    logic [SIZE_W-1:0]   out_height;
    logic [STRIDE_W-1:0] src_stride;
    logic [STRIDE_W-1:0] dst_stride;
    logic [START_W-1:0]  dst_start_x;
    logic [START_W-1:0]  dst_start_y;
  } cfg_t;

  // One classified pixel: the position it was generated at and its flags.
  typedef struct packed {
    logic [ACC_W-1:0] acc_row;
    logic [ACC_W-1:0] acc_col;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             row_end;
    logic             frame_end;
  } q_entry_t;

  // Index of the last position along an axis; zero acts as one and the
  // size is capped at 4096.
  function automatic logic [POS_W-1:0] size_last(input logic [SIZE_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > SIZE_MAX) begin
      r = '1;
    end else begin
      r = POS_W'(v - SIZE_W'(1));
    end
    return r;
  endfunction

endpackage

// ===== design/nnsa_in_if.sv =====
// ----------------------------------------------------------------------------
// nnsa_in_if: input channel of the scaler address generator
// Valid/ready channel carrying the restart flag of one pixel.
// ----------------------------------------------------------------------------
interface nnsa_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

// ===== design/nnsa_out_if.sv =====
// ----------------------------------------------------------------------------
// nnsa_out_if: result channel of the scaler address generator
// Valid/ready channel carrying both byte offsets and the run flags.
// ----------------------------------------------------------------------------
interface nnsa_out_if;
  logic                          valid;
  logic                          ready;
  logic [nnsa_pkg::ADDR_W-1:0]   src_offset;
  logic [nnsa_pkg::ADDR_W-1:0]   dst_offset;
  logic                          row_end;
  logic                          frame_end;

  modport source (output valid, output src_offset, output dst_offset,
                  output row_end, output frame_end, input ready);
  modport sink (input valid, input src_offset, input dst_offset,
                input row_end, input frame_end, output ready);
endinterface

// ===== design/nnsa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// nnsa_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface nnsa_cfg_if;
  logic                             valid;
  logic                             ready;
  nnsa_pkg::cfg_idx_t               index;
  logic [nnsa_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/nnsa_front.sv =====
// ----------------------------------------------------------------------------
// nnsa_front: position tracker
// Holds the accumulators and counters, classifies each pixel and steps on.
// ----------------------------------------------------------------------------
module nnsa_front (
  input  logic               clk,
  input  logic               rst_n,
  input  nnsa_pkg::cfg_t     cfg,
  nnsa_in_if.sink            in_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output nnsa_pkg::q_entry_t push_entry
);

  localparam int ACC_W = nnsa_pkg::ACC_W;
  localparam int POS_W = nnsa_pkg::POS_W;

  logic [ACC_W-1:0] acc_col_r, acc_col_nxt;
  logic [ACC_W-1:0] acc_row_r, acc_row_nxt;
  logic [POS_W-1:0] out_col_r, out_col_nxt;
  logic [POS_W-1:0] out_row_r, out_row_nxt;

  logic [ACC_W-1:0] cur_acc_col, cur_acc_row;
  logic [POS_W-1:0] cur_out_col, cur_out_row;
  logic [POS_W-1:0] col_last, row_last;
  logic             last_col, last_row;
  logic [ACC_W:0]   col_sum, row_sum;
  logic             accept;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid && push_ready;

  // A restart clears the position before this pixel is classified.
  assign cur_acc_col = in_ch.restart ? '0 : acc_col_r;
  assign cur_acc_row = in_ch.restart ? '0 : acc_row_r;
  assign cur_out_col = in_ch.restart ? '0 : out_col_r;
  assign cur_out_row = in_ch.restart ? '0 : out_row_r;

  assign col_last = nnsa_pkg::size_last(cfg.out_width);
  assign row_last = nnsa_pkg::size_last(cfg.out_height);
  assign last_col = cur_out_col >= col_last;
  assign last_row = cur_out_row >= row_last;

  assign col_sum = {1'b0, cur_acc_col} + (ACC_W+1)'(cfg.step_x);
  assign row_sum = {1'b0, cur_acc_row} + (ACC_W+1)'(cfg.step_y);

  always_comb begin
    push_entry.acc_row   = cur_acc_row;
    push_entry.acc_col   = cur_acc_col;
    push_entry.out_row   = cur_out_row;
    push_entry.out_col   = cur_out_col;
    push_entry.row_end   = last_col;
    push_entry.frame_end = last_col && last_row;
  end

  always_comb begin
    acc_col_nxt = acc_col_r;
    acc_row_nxt = acc_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (accept) begin
      if (!last_col) begin
        acc_col_nxt = col_sum[ACC_W] ? '1 : col_sum[ACC_W-1:0];
        acc_row_nxt = cur_acc_row;
        out_col_nxt = cur_out_col + POS_W'(1);
        out_row_nxt = cur_out_row;
      end else if (!last_row) begin
        acc_col_nxt = '0;
        out_col_nxt = '0;
        acc_row_nxt = row_sum[ACC_W] ? '1 : row_sum[ACC_W-1:0];
        out_row_nxt = cur_out_row + POS_W'(1);
      end else begin
        acc_col_nxt = '0;
        acc_row_nxt = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_col_r <= '0;
      acc_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      acc_col_r <= acc_col_nxt;
      acc_row_r <= acc_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

endmodule

// ===== design/nnsa_fifo.sv =====
// ----------------------------------------------------------------------------
// nnsa_fifo: short queue between position tracker and address stage
// Register-based FIFO of classified pixels.
// ----------------------------------------------------------------------------
module nnsa_fifo #(
  parameter int DEPTH = nnsa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  nnsa_pkg::q_entry_t push_entry,
  output logic               pop_valid,
  input  logic               pop_ready,
  output nnsa_pkg::q_entry_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  nnsa_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond its depth");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (do_push && !do_pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue occupancy did not follow a lone push");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers differ while empty");

endmodule

// ===== design/nnsa_back.sv =====
// ----------------------------------------------------------------------------
// nnsa_back: address stage
// Multiplies row indices by the strides, then adds columns and saturates.
// ----------------------------------------------------------------------------
module nnsa_back #(
  parameter int FRAC_BITS = nnsa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  nnsa_pkg::cfg_t     cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  nnsa_pkg::q_entry_t pop_entry,
  nnsa_out_if.source         out_ch
);

  localparam int ACC_W    = nnsa_pkg::ACC_W;
  localparam int ADDR_W   = nnsa_pkg::ADDR_W;
  localparam int POS_W    = nnsa_pkg::POS_W;
  localparam int STRIDE_W = nnsa_pkg::STRIDE_W;
  localparam int SRW      = ACC_W - FRAC_BITS;     // source index width
  localparam int SPW      = SRW + STRIDE_W;        // source row product width
  localparam int SSW      = SPW + 1;               // source sum width
  localparam int DRW      = POS_W + 1;             // destination row width
  localparam int DPW      = DRW + STRIDE_W;        // destination product width
  localparam int DSW      = DPW + 1;               // destination sum width

  // Product stage
  logic             s1_v_r, s1_v_nxt;
  logic [SPW-1:0]   s1_src_prod_r;
  logic [SRW-1:0]   s1_src_col_r;
  logic [DPW-1:0]   s1_dst_prod_r;
  logic [DRW-1:0]   s1_dst_col_r;
  logic             s1_row_end_r;
  logic             s1_frame_end_r;

  // Output stage
  logic              out_v_r, out_v_nxt;
  logic [ADDR_W-1:0] src_off_r;
  logic [ADDR_W-1:0] dst_off_r;
  logic              row_end_r;
  logic              frame_end_r;

  logic              s1_ready, out_adv;
  logic [SRW-1:0]    src_row;
  logic [DRW-1:0]    dst_row;
  logic [SSW-1:0]    src_sum;
  logic [DSW-1:0]    dst_sum;

  assign out_adv   = !out_v_r || out_ch.ready;
  assign s1_ready  = !s1_v_r || out_adv;
  assign pop_ready = s1_ready;

  assign src_row = pop_entry.acc_row[ACC_W-1:FRAC_BITS];
  assign dst_row = DRW'(pop_entry.out_row) + DRW'(cfg.dst_start_y);

  assign src_sum = SSW'(s1_src_prod_r) + SSW'(s1_src_col_r);
  assign dst_sum = DSW'(s1_dst_prod_r) + DSW'(s1_dst_col_r);

  assign s1_v_nxt  = s1_ready ? pop_valid : s1_v_r;
  assign out_v_nxt = out_adv ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pop_valid) begin
      s1_src_prod_r  <= SPW'(src_row) * SPW'(cfg.src_stride);
      s1_src_col_r   <= pop_entry.acc_col[ACC_W-1:FRAC_BITS];
      s1_dst_prod_r  <= DPW'(dst_row) * DPW'(cfg.dst_stride);
      s1_dst_col_r   <= DRW'(cfg.dst_start_x) + DRW'(pop_entry.out_col);
      s1_row_end_r   <= pop_entry.row_end;
      s1_frame_end_r <= pop_entry.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_v_r) begin
      src_off_r   <= (src_sum > SSW'(nnsa_pkg::ADDR_MAX)) ? nnsa_pkg::ADDR_MAX
                                                          : ADDR_W'(src_sum);
      dst_off_r   <= (dst_sum > DSW'(nnsa_pkg::ADDR_MAX)) ? nnsa_pkg::ADDR_MAX
                                                          : ADDR_W'(dst_sum);
      row_end_r   <= s1_row_end_r;
      frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.src_offset = src_off_r;
  assign out_ch.dst_offset = dst_off_r;
  assign out_ch.row_end    = row_end_r;
  assign out_ch.frame_end  = frame_end_r;

  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_v_r && frame_end_r) |-> row_end_r)
    else $error("frame end flagged on a pixel that does not end its row");

endmodule

// ===== design/nearest_neighbor_scaler_addresses_core.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_scaler_addresses_core: nearest-neighbour address generator
// Configuration registers, position tracker, queue and address stage.
// ----------------------------------------------------------------------------
// The block takes one pixel request per clock while the queue has room and
// returns, in raster order, the source and destination byte offsets of that
// pixel with row-end and frame-end flags. Throughput is one transfer per clock
// in both directions when the receiver does not hold off; it is set by the
// accumulator update in the position tracker. An accepted request is written
// into the queue, the product stage then registers the stride products and the
// output stage adds the columns and saturates; a stall at the output can hold
// a result in the queue or either stage. Configuration writes complete in the
// cycle they are presented and should only be made while no pixel is in flight.
// The source column and row are the integer parts of the horizontal and
// vertical accumulators, whose fraction width is FRAC_BITS.
module nearest_neighbor_scaler_addresses_core #(
  parameter int FRAC_BITS   = nnsa_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = nnsa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  nnsa_in_if.sink     in_ch,
  nnsa_out_if.source  out_ch,
  nnsa_cfg_if.sink    cfg_ch
);

  nnsa_pkg::cfg_t     cfg_r, cfg_nxt;
  logic               push_valid, push_ready;
  nnsa_pkg::q_entry_t push_entry;
  logic               pop_valid, pop_ready;
  nnsa_pkg::q_entry_t pop_entry;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        nnsa_pkg::CFG_STEP_X:      cfg_nxt.step_x      = cfg_ch.data;
        nnsa_pkg::CFG_STEP_Y:      cfg_nxt.step_y      = cfg_ch.data;
        nnsa_pkg::CFG_OUT_WIDTH:   cfg_nxt.out_width   = cfg_ch.data[nnsa_pkg::SIZE_W-1:0];
        nnsa_pkg::CFG_OUT_HEIGHT:  cfg_nxt.out_height  = cfg_ch.data[nnsa_pkg::SIZE_W-1:0];
        nnsa_pkg::CFG_SRC_STRIDE:  cfg_nxt.src_stride  = cfg_ch.data[nnsa_pkg::STRIDE_W-1:0];
        nnsa_pkg::CFG_DST_STRIDE:  cfg_nxt.dst_stride  = cfg_ch.data[nnsa_pkg::STRIDE_W-1:0];
        nnsa_pkg::CFG_DST_START_X: cfg_nxt.dst_start_x = cfg_ch.data[nnsa_pkg::START_W-1:0];
        nnsa_pkg::CFG_DST_START_Y: cfg_nxt.dst_start_y = cfg_ch.data[nnsa_pkg::START_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_x      <= nnsa_pkg::STEP_RESET;
      cfg_r.step_y      <= nnsa_pkg::STEP_RESET;
      cfg_r.out_width   <= nnsa_pkg::SIZE_W'(1);
      cfg_r.out_height  <= nnsa_pkg::SIZE_W'(1);
      cfg_r.src_stride  <= nnsa_pkg::STRIDE_W'(1);
      cfg_r.dst_stride  <= nnsa_pkg::STRIDE_W'(1);
      cfg_r.dst_start_x <= '0;
      cfg_r.dst_start_y <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nnsa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  nnsa_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  nnsa_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the nearest-neighbour address generator
// Drives restart flags with random gaps, writes the register set between
// phases and compares every returned offset pair and flag set against an
// in-bench model of the scan position and fixed-point accumulators.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FRAC       = nnsa_pkg::FRAC_BITS_DEF;
  localparam int ACC_W      = nnsa_pkg::ACC_W;
  localparam int ADDR_W     = nnsa_pkg::ADDR_W;
  localparam int STEP_W     = nnsa_pkg::STEP_W;
  localparam int SIZE_W     = nnsa_pkg::SIZE_W;
  localparam int POS_W      = nnsa_pkg::POS_W;
  localparam int STRIDE_W   = nnsa_pkg::STRIDE_W;
  localparam int START_W    = nnsa_pkg::START_W;
  localparam int CFG_DATA_W = nnsa_pkg::CFG_DATA_W;
  localparam int LATENCY    = 3;
  localparam int HOLD_LEN   = 200;
  localparam int HOLD_AT    = 100;

  typedef struct packed {
    logic [ADDR_W-1:0] src_off;
    logic [ADDR_W-1:0] dst_off;
    logic              row_end;
    logic              frame_end;
  } pixel_addr_t;

  logic clk;
  logic rst_n;

  nnsa_in_if  pix_in();
  nnsa_out_if addr_out();
  nnsa_cfg_if cfg_bus();

  nearest_neighbor_scaler_addresses_core #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (pix_in),
    .out_ch(addr_out),
    .cfg_ch(cfg_bus)
  );

  // Model state: register shadow, accumulators and output position.
  nnsa_pkg::cfg_t   regs;
  logic [ACC_W-1:0] acc_col;
  logic [ACC_W-1:0] acc_row;
  logic [POS_W-1:0] col_pos;
  logic [POS_W-1:0] row_pos;

  logic        pixel_reqs[$];
  pixel_addr_t pending_addrs[$];

  int unsigned pushed_cnt;
  int unsigned accepted_cnt;
  int unsigned checked_cnt;
  int unsigned error_cnt;
  int unsigned gap_left, calm_in, stall_left, calm_out;
  logic        sink_hold;
  pixel_addr_t got_pixel, want_pixel;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int unsigned eff_dim(input logic [SIZE_W-1:0] v);
    if (v == '0) return 1;
    if (v > SIZE_W'(4096)) return 4096;
    return v;
  endfunction

  function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W-1:0] a,
                                               input logic [STEP_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + (ACC_W+1)'(b);
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  function automatic void clear_scan();
    acc_col = '0;
    acc_row = '0;
    col_pos = '0;
    row_pos = '0;
  endfunction

  // Works out the offsets and flags of the next pixel and moves the scan on.
  task automatic map_pixel(input logic restart);
    int unsigned     w, h;
    longint unsigned src_row, src_col, s_off, d_off;
    logic            last_col, last_row;
    pixel_addr_t     r;
    w = eff_dim(regs.out_width);
    h = eff_dim(regs.out_height);
    if (restart) clear_scan();
    src_row = longint'(acc_row >> FRAC);
    src_col = longint'(acc_col >> FRAC);
    s_off = src_row * longint'(regs.src_stride) + src_col;
    d_off = (longint'(row_pos) + longint'(regs.dst_start_y)) * longint'(regs.dst_stride)
            + longint'(regs.dst_start_x) + longint'(col_pos);
    last_col = (col_pos >= w - 1);
    last_row = (row_pos >= h - 1);
    r.src_off   = (s_off > nnsa_pkg::ADDR_MAX) ? nnsa_pkg::ADDR_MAX : s_off[ADDR_W-1:0];
    r.dst_off   = (d_off > nnsa_pkg::ADDR_MAX) ? nnsa_pkg::ADDR_MAX : d_off[ADDR_W-1:0];
    r.row_end   = last_col;
    r.frame_end = last_col && last_row;
    pending_addrs.push_back(r);
    if (!last_col) begin
      acc_col = sat_acc(acc_col, regs.step_x);
      col_pos = col_pos + POS_W'(1);
    end else if (!last_row) begin
      acc_col = '0;
      col_pos = '0;
      acc_row = sat_acc(acc_row, regs.step_y);
      row_pos = row_pos + POS_W'(1);
    end else begin
      clear_scan();
    end
  endtask

  // Only the bits of each register's own width are kept.
  task automatic write_reg(input nnsa_pkg::cfg_idx_t idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      nnsa_pkg::CFG_STEP_X:      regs.step_x      = val[STEP_W-1:0];
      nnsa_pkg::CFG_STEP_Y:      regs.step_y      = val[STEP_W-1:0];
      nnsa_pkg::CFG_OUT_WIDTH:   regs.out_width   = val[SIZE_W-1:0];
      nnsa_pkg::CFG_OUT_HEIGHT:  regs.out_height  = val[SIZE_W-1:0];
      nnsa_pkg::CFG_SRC_STRIDE:  regs.src_stride  = val[STRIDE_W-1:0];
      nnsa_pkg::CFG_DST_STRIDE:  regs.dst_stride  = val[STRIDE_W-1:0];
      nnsa_pkg::CFG_DST_START_X: regs.dst_start_x = val[START_W-1:0];
      nnsa_pkg::CFG_DST_START_Y: regs.dst_start_y = val[START_W-1:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic queue_pixel(input logic restart);
    pixel_reqs.push_back(restart);
    pushed_cnt++;
  endtask

  task automatic settle();
    wait (checked_cnt == pushed_cnt);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Pixel request driver; the model is advanced on every accepted transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_in.valid   <= 1'b0;
      pix_in.restart <= 1'b0;
      gap_left = 0;
    end else begin
      if (pix_in.valid && pix_in.ready) begin
        map_pixel(pix_in.restart);
        accepted_cnt++;
      end
      if (!pix_in.valid || pix_in.ready) begin
        if (gap_left > 0 && !sink_hold) begin
          gap_left--;
          pix_in.valid <= 1'b0;
        end else if (pixel_reqs.size() > 0) begin
          pix_in.valid   <= 1'b1;
          pix_in.restart <= pixel_reqs.pop_front();
          if (calm_in > 0) begin
            calm_in--;
            gap_left = 0;
          end else begin
            gap_left = idle_len();
            if ($urandom_range(0, 49) == 0) calm_in = $urandom_range(20, 60);
          end
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      addr_out.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (addr_out.valid && addr_out.ready) begin
        got_pixel = '{addr_out.src_offset, addr_out.dst_offset,
                      addr_out.row_end, addr_out.frame_end};
        if (pending_addrs.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("unexpected transfer: src %h dst %h row_end %b frame_end %b",
                     got_pixel.src_off, got_pixel.dst_off,
                     got_pixel.row_end, got_pixel.frame_end);
        end else begin
          want_pixel = pending_addrs.pop_front();
          if (got_pixel !== want_pixel) begin
            error_cnt++;
            if (error_cnt <= 10)
              $display({"mismatch at pixel %0d (expected/actual): src %h/%h ",
                        "dst %h/%h row_end %b/%b frame_end %b/%b"}, checked_cnt,
                       want_pixel.src_off, got_pixel.src_off,
                       want_pixel.dst_off, got_pixel.dst_off,
                       want_pixel.row_end, got_pixel.row_end,
                       want_pixel.frame_end, got_pixel.frame_end);
          end
          checked_cnt++;
        end
      end
      if (sink_hold) begin
        addr_out.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        addr_out.ready <= 1'b0;
      end else begin
        addr_out.ready <= 1'b1;
        if (calm_out > 0) begin
          calm_out--;
        end else begin
          stall_left = idle_len();
          if ($urandom_range(0, 49) == 0) calm_out = $urandom_range(20, 60);
        end
      end
    end
  end

  // Long receiver hold-off while requests keep coming, so the block backs up.
  initial begin
    sink_hold = 1'b0;
    wait (accepted_cnt >= HOLD_AT);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin
    #(20 * 400000);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned sel;
    logic [CFG_DATA_W-1:0] val;

    rst_n          = 1'b0;
    pix_in.valid   = 1'b0;
    pix_in.restart = 1'b0;
    addr_out.ready = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = nnsa_pkg::CFG_STEP_X;
    cfg_bus.data   = '0;
    pushed_cnt     = 0;
    accepted_cnt   = 0;
    checked_cnt    = 0;
    error_cnt      = 0;
    calm_in        = 0;
    calm_out       = 0;
    regs.step_x      = nnsa_pkg::STEP_RESET;
    regs.step_y      = nnsa_pkg::STEP_RESET;
    regs.out_width   = SIZE_W'(1);
    regs.out_height  = SIZE_W'(1);
    regs.src_stride  = STRIDE_W'(1);
    regs.dst_stride  = STRIDE_W'(1);
    regs.dst_start_x = '0;
    regs.dst_start_y = '0;
    clear_scan();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults: a one-pixel frame, so every pixel ends the frame.
    queue_pixel(1'b0);
    queue_pixel(1'b1);
    settle();

    // Largest steps, strides, start: dst offsets saturate, src on last three rows.
    write_reg(nnsa_pkg::CFG_STEP_X, 24'hFFFFFF);
    write_reg(nnsa_pkg::CFG_STEP_Y, 24'hFFFFFF);
    write_reg(nnsa_pkg::CFG_OUT_WIDTH, 24'd1);
    write_reg(nnsa_pkg::CFG_OUT_HEIGHT, 24'd8);
    write_reg(nnsa_pkg::CFG_SRC_STRIDE, 24'd16383);
    write_reg(nnsa_pkg::CFG_DST_STRIDE, 24'd16383);
    write_reg(nnsa_pkg::CFG_DST_START_X, 24'd4095);
    write_reg(nnsa_pkg::CFG_DST_START_Y, 24'd4095);
    queue_pixel(1'b1);
    repeat (7) queue_pixel(1'b0);
    settle();

    // Zero steps and strides; a zero width acts as one, an oversized
    // height as 4096.
    write_reg(nnsa_pkg::CFG_STEP_X, 24'd0);
    write_reg(nnsa_pkg::CFG_STEP_Y, 24'd0);
    write_reg(nnsa_pkg::CFG_OUT_WIDTH, 24'd0);
    write_reg(nnsa_pkg::CFG_OUT_HEIGHT, 24'd8191);
    write_reg(nnsa_pkg::CFG_SRC_STRIDE, 24'd0);
    write_reg(nnsa_pkg::CFG_DST_STRIDE, 24'd0);
    write_reg(nnsa_pkg::CFG_DST_START_X, 24'd0);
    write_reg(nnsa_pkg::CFG_DST_START_Y, 24'd0);
    queue_pixel(1'b0);
    queue_pixel(1'b0);
    queue_pixel(1'b1);
    queue_pixel(1'b0);
    settle();

    // Oversized width and zero height, stopped part-way along the row.
    write_reg(nnsa_pkg::CFG_STEP_X, 24'h018000);
    write_reg(nnsa_pkg::CFG_STEP_Y, 24'h010000);
    write_reg(nnsa_pkg::CFG_OUT_WIDTH, 24'd8191);
    write_reg(nnsa_pkg::CFG_OUT_HEIGHT, 24'd0);
    write_reg(nnsa_pkg::CFG_SRC_STRIDE, 24'd100);
    write_reg(nnsa_pkg::CFG_DST_STRIDE, 24'd200);
    write_reg(nnsa_pkg::CFG_DST_START_X, 24'd10);
    write_reg(nnsa_pkg::CFG_DST_START_Y, 24'd20);
    queue_pixel(1'b1);
    repeat (4) queue_pixel(1'b0);
    settle();

    // The width now shrinks below the current column, which then counts as
    // the last one of its row.
    write_reg(nnsa_pkg::CFG_OUT_WIDTH, 24'd2);
    queue_pixel(1'b0);
    queue_pixel(1'b0);
    settle();

    // A tall one-pixel-wide frame takes the row accumulator into saturation.
    write_reg(nnsa_pkg::CFG_STEP_X, CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
    write_reg(nnsa_pkg::CFG_STEP_Y, 24'hFFFFFF);
    write_reg(nnsa_pkg::CFG_OUT_WIDTH, 24'd1);
    write_reg(nnsa_pkg::CFG_OUT_HEIGHT, 24'd4096);
    write_reg(nnsa_pkg::CFG_SRC_STRIDE, CFG_DATA_W'($urandom_range(1, 255)));
    write_reg(nnsa_pkg::CFG_DST_STRIDE, CFG_DATA_W'($urandom_range(0, 16383)));
    write_reg(nnsa_pkg::CFG_DST_START_X, CFG_DATA_W'($urandom_range(0, 4095)));
    write_reg(nnsa_pkg::CFG_DST_START_Y, CFG_DATA_W'($urandom_range(0, 4095)));
    queue_pixel(1'b1);
    repeat (259) queue_pixel(1'b0);
    settle();

    // A full-width row takes the column accumulator into saturation.
    write_reg(nnsa_pkg::CFG_STEP_X, 24'hFFFFFF);
    write_reg(nnsa_pkg::CFG_STEP_Y, CFG_DATA_W'($urandom_range(1, 24'h3FFFF)));
    write_reg(nnsa_pkg::CFG_OUT_WIDTH, 24'd4096);
    write_reg(nnsa_pkg::CFG_OUT_HEIGHT, 24'd2);
    queue_pixel(1'b1);
    repeat (259) queue_pixel(1'b0);
    settle();

    // Mixed settings: mostly small frames with occasional restarts. Upper
    // bits beyond a register's width carry random data.
    for (int ph = 0; ph < 4; ph++) begin
      sel = $urandom_range(0, 3);
      case (sel)
        0: val = CFG_DATA_W'($urandom_range(1, 24'h3FFFF));
        1: val = 24'h010000;
        2: val = CFG_DATA_W'($urandom);
        default: val = CFG_DATA_W'($urandom_range(0, 24'hFFFF));
      endcase
      write_reg(nnsa_pkg::CFG_STEP_X, val);
      write_reg(nnsa_pkg::CFG_STEP_Y,
                CFG_DATA_W'((sel == 2) ? 1 : $urandom_range(0, 24'h3FFFF)));
      sel = $urandom_range(0, 9);
      val = CFG_DATA_W'($urandom);
      val[SIZE_W-1:0] = SIZE_W'((sel < 8) ? $urandom_range(1, 12)
                              : (sel == 8) ? 0 : $urandom_range(4097, 8191));
      write_reg(nnsa_pkg::CFG_OUT_WIDTH, val);
      val = CFG_DATA_W'($urandom);
      val[SIZE_W-1:0] = SIZE_W'($urandom_range(0, 6));
      write_reg(nnsa_pkg::CFG_OUT_HEIGHT, val);
      val = CFG_DATA_W'($urandom);
      write_reg(nnsa_pkg::CFG_SRC_STRIDE, val);
      val = CFG_DATA_W'($urandom);
      write_reg(nnsa_pkg::CFG_DST_STRIDE, val);
      val = CFG_DATA_W'($urandom);
      write_reg(nnsa_pkg::CFG_DST_START_X, val);
      val = CFG_DATA_W'($urandom);
      write_reg(nnsa_pkg::CFG_DST_START_Y, val);
      n = $urandom_range(8, 16);
      repeat (n) queue_pixel($urandom_range(0, 11) == 0);
      settle();
    end

    if (error_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/nnsa_pkg.sv
design/nnsa_in_if.sv
design/nnsa_out_if.sv
design/nnsa_cfg_if.sv
design/nnsa_front.sv
design/nnsa_fifo.sv
design/nnsa_back.sv
design/nearest_neighbor_scaler_addresses_core.sv
verif/testbench.sv
